// ----- src/untp_pkg.sv -----
// ----------------------------------------------------------------------------
// untp_pkg
// Shared types and constants for the unsigned number text parser: character
// codes, the scan phase, and the structs passed between the parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package untp_pkg;

	localparam int CHAR_W  = 16;
	localparam int VALUE_W = 64;
	localparam int DIGIT_W = 4;

	localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
	localparam logic [CHAR_W-1:0] CH_TAB   = 16'h0009;
	localparam logic [CHAR_W-1:0] CH_CR    = 16'h000D;
	localparam logic [CHAR_W-1:0] CH_LF    = 16'h000A;
	localparam logic [CHAR_W-1:0] CH_0     = 16'h0030;
	localparam logic [CHAR_W-1:0] CH_9     = 16'h0039;
	localparam logic [CHAR_W-1:0] CH_LA    = 16'h0061;
	localparam logic [CHAR_W-1:0] CH_LF_HEX = 16'h0066;
	localparam logic [CHAR_W-1:0] CH_UA    = 16'h0041;
	localparam logic [CHAR_W-1:0] CH_UF    = 16'h0046;
	localparam logic [CHAR_W-1:0] CH_LX    = 16'h0078;
	localparam logic [CHAR_W-1:0] CH_UX    = 16'h0058;

	// Letters a-f and A-F share a low nibble one above their value minus ten.
	localparam logic [DIGIT_W-1:0] HEX_LETTER_OFS = 4'd9;

	typedef enum logic [2:0] {
		PH_LEAD   = 3'd0,
		PH_ZERO   = 3'd1,
		PH_PREFIX = 3'd2,
		PH_DIGITS = 3'd3,
		PH_TRAIL  = 3'd4
	} phase_t;

	// One character leaving the input register.
	typedef struct packed {
		logic              fire;
		logic              last;
		logic [CHAR_W-1:0] code;
	} step_t;

	// Digit decode and accumulate result.
	typedef struct packed {
		logic               is_digit;
		logic               is_zero;
		logic               over;
		logic [VALUE_W-1:0] acc_next;
	} dig_t;

	// Result of a text, valid on its final character.
	typedef struct packed {
		logic               ok;
		logic [VALUE_W-1:0] value;
	} res_t;

	function automatic logic is_blank(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

endpackage

`default_nettype wire

// ----- src/unsigned_number_text_parser_core.sv -----
// ----------------------------------------------------------------------------
// unsigned_number_text_parser_core
// Parses a decimal or 0x-prefixed hexadecimal unsigned number from a stream
// of UTF-16 code units, checking it against a configurable maximum.
//
// Usage:
// - Input channel (in_valid / in_stall) carries one code unit per word,
//   char_code, with last_char set on the final unit of a text. An empty text
//   is sent as a single space.
// - Output channel (out_valid / out_stall) gives one word per text:
//   parse_ok, and parsed_value (zero when parse_ok is low).
// - Configuration channel (cfg_valid / cfg_ready / cfg_data) writes the
//   maximum value; cfg_ready is always high. Write only while idle.
// - A word is registered in the input register at acceptance and scanned from
//   there; the result of a final unit is registered again and drives out_valid.
// - One code unit per cycle is sustained unless a final unit waits on a
//   stalled output word; the digit step (a multiply by ten or sixteen by
//   shift-add, then a 68-bit compare with the limit) is combinational.
// - If the output word is stalled, a following final unit waits in the input
//   register and in_stall rises; non-final units keep flowing meanwhile.
// - Reset clears the text in progress, drops any pending word and sets the
//   maximum to all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module unsigned_number_text_parser_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [untp_pkg::CHAR_W-1:0]  char_code,
	input  wire logic                         last_char,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              parse_ok,
	output logic [untp_pkg::VALUE_W-1:0]      parsed_value,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [untp_pkg::VALUE_W-1:0] cfg_data
);
	import untp_pkg::*;

	logic               valid_s1;
	logic [CHAR_W-1:0]  code_s1;
	logic               last_s1;
	logic [VALUE_W-1:0] max_value_q;
	logic               out_valid_q;
	res_t               res_q;
	res_t               res;
	step_t              step;
	logic               fire;

	// A final unit may only leave the input register if the result slot frees.
	assign fire     = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire;
	assign cfg_ready = 1'b1;

	assign step.fire = fire;
	assign step.last = last_s1;
	assign step.code = code_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			code_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_value_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			max_value_q <= cfg_data;
		end
	end

	untp_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.max_value (max_value_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s1) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign parse_ok     = res_q.ok;
	assign parsed_value = res_q.value;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !parse_ok |-> parsed_value == '0)
		else $error("failed parse carries a non-zero value");

	a_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && parse_ok |-> parsed_value <= max_value_q)
		else $error("accepted value exceeds the configured maximum");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(fire && last_s1))
		else $error("result word appeared without a final unit");

	a_nonfinal_flows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !last_s1 |-> !in_stall)
		else $error("non-final unit held in the input register");

endmodule

`default_nettype wire

// ----- src/untp_digit_acc.sv -----
// ----------------------------------------------------------------------------
// untp_digit_acc
// Decodes one character as a decimal or hexadecimal digit and forms
// accum * base + digit at full width, flagging a result above the limit.
// ----------------------------------------------------------------------------
`default_nettype none

module untp_digit_acc (
	input  wire logic [untp_pkg::CHAR_W-1:0]  code,
	input  wire logic                         hex,
	input  wire logic [untp_pkg::VALUE_W-1:0] accum,
	input  wire logic [untp_pkg::VALUE_W-1:0] max_value,
	output untp_pkg::dig_t                    dig
);
	import untp_pkg::*;

	localparam int WIDE_W = VALUE_W + DIGIT_W;

	logic               valid;
	logic [DIGIT_W-1:0] dval;
	logic [WIDE_W-1:0]  acc_wide;
	logic [WIDE_W-1:0]  prod;
	logic [WIDE_W-1:0]  sum;

	always_comb begin
		valid = 1'b0;
		dval  = '0;
		case (code) inside
			[CH_0:CH_9]: begin
				valid = 1'b1;
				dval  = code[DIGIT_W-1:0];
			end
			[CH_LA:CH_LF_HEX], [CH_UA:CH_UF]: begin
				valid = hex;
				dval  = code[DIGIT_W-1:0] + HEX_LETTER_OFS;
			end
			default: begin
				valid = 1'b0;
				dval  = '0;
			end
		endcase
	end

	// The product is kept four bits wider so the limit test never wraps.
	assign acc_wide = {{DIGIT_W{1'b0}}, accum};
	assign prod = hex ? {accum, {DIGIT_W{1'b0}}} : ((acc_wide << 3) + (acc_wide << 1));
	assign sum  = prod + {{VALUE_W{1'b0}}, dval};

	assign dig.is_digit = valid;
	assign dig.is_zero  = (dval == '0);
	assign dig.over     = (sum > {{DIGIT_W{1'b0}}, max_value});
	assign dig.acc_next = sum[VALUE_W-1:0];

endmodule

`default_nettype wire

// ----- src/untp_scan.sv -----
// ----------------------------------------------------------------------------
// untp_scan
// Text scanner: holds the phase, base, running value and failure flag of
// the text in progress, and forms the result on its final character.
// ----------------------------------------------------------------------------
`default_nettype none

module untp_scan (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire untp_pkg::step_t              step,
	input  wire logic [untp_pkg::VALUE_W-1:0] max_value,
	output untp_pkg::res_t                    res
);
	import untp_pkg::*;

	phase_t             phase_q, phase_d;
	logic               hex_mode_q, hex_mode_d;
	logic [VALUE_W-1:0] accum_q, accum_d;
	logic               failed_q, failed_d;
	dig_t               dig;
	logic               blank;

	untp_digit_acc u_digit_acc (
		.code      (step.code),
		.hex       (hex_mode_q),
		.accum     (accum_q),
		.max_value (max_value),
		.dig       (dig)
	);

	assign blank = is_blank(step.code);

	// Next state for the current character, before the end-of-text clear.
	always_comb begin
		phase_d    = phase_q;
		hex_mode_d = hex_mode_q;
		accum_d    = accum_q;
		failed_d   = failed_q;
		if (!failed_q) begin
			case (phase_q)
				PH_LEAD: begin
					if (!blank) begin
						if (!dig.is_digit || dig.over) begin
							failed_d = 1'b1;
						end else begin
							phase_d = dig.is_zero ? PH_ZERO : PH_DIGITS;
							accum_d = dig.acc_next;
						end
					end
				end
				PH_ZERO: begin
					if (step.code == CH_LX || step.code == CH_UX) begin
						hex_mode_d = 1'b1;
						phase_d    = PH_PREFIX;
					end else if (blank) begin
						phase_d = PH_TRAIL;
					end else if (!dig.is_digit || dig.over) begin
						failed_d = 1'b1;
					end else begin
						phase_d = PH_DIGITS;
						accum_d = dig.acc_next;
					end
				end
				PH_PREFIX: begin
					if (!dig.is_digit || dig.over) begin
						failed_d = 1'b1;
					end else begin
						phase_d = PH_DIGITS;
						accum_d = dig.acc_next;
					end
				end
				PH_DIGITS: begin
					if (blank) begin
						phase_d = PH_TRAIL;
					end else if (!dig.is_digit || dig.over) begin
						failed_d = 1'b1;
					end else begin
						accum_d = dig.acc_next;
					end
				end
				PH_TRAIL: begin
					if (!blank) begin
						failed_d = 1'b1;
					end
				end
				default: begin
					failed_d = 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		res.ok    = !failed_d && (phase_d == PH_ZERO || phase_d == PH_DIGITS ||
			phase_d == PH_TRAIL);
		res.value = res.ok ? accum_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LEAD;
			hex_mode_q <= 1'b0;
			accum_q    <= '0;
			failed_q   <= 1'b0;
		end else if (step.fire) begin
			if (step.last) begin
				phase_q    <= PH_LEAD;
				hex_mode_q <= 1'b0;
				accum_q    <= '0;
				failed_q   <= 1'b0;
			end else begin
				phase_q    <= phase_d;
				hex_mode_q <= hex_mode_d;
				accum_q    <= accum_d;
				failed_q   <= failed_d;
			end
		end
	end

endmodule

`default_nettype wire
